### rtl/hid_key_rollover_tap_top_assert.svh
// ----------------------------------------------------------------------------
// hid key rollover tap assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef HID_KEY_ROLLOVER_TAP_TOP_ASSERT_SVH
`define HID_KEY_ROLLOVER_TAP_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define HKR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HKR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hkr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkr_pkg
// shared constants, codes and types of the key rollover tap block
// ----------------------------------------------------------------------------
package hkr_pkg;

  localparam int LIST_DEPTH  = 16;
  localparam int REPORT_KEYS = 6;
  localparam int IDX_W       = $clog2(LIST_DEPTH);
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int KEY_W       = 8;
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 5;
  localparam int DELAY_W     = 8;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd5;

  // register index
  localparam logic REG_TAP_DELAY = 1'b0;

  // action codes
  localparam logic [2:0] ACT_PRESS   = 3'd0;
  localparam logic [2:0] ACT_RELEASE = 3'd1;
  localparam logic [2:0] ACT_REPORT  = 3'd2;
  localparam logic [2:0] ACT_TAP     = 3'd3;
  localparam logic [2:0] ACT_POLL    = 3'd4;

  // tap phases
  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_PRESS   = 2'd1;
  localparam logic [1:0] PHASE_RELEASE = 2'd2;
  localparam logic [1:0] PHASE_SPARE   = 2'd3;

  typedef logic [REPORT_KEYS-1:0][KEY_W-1:0] slots_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [KEY_W-1:0]  keycode;
    logic [TIME_W-1:0] now_ms;
    logic              host_ready;
    logic              host_accepts;
  } in_item_t;

  typedef struct packed {
    slots_t             slots;
    logic               was_sent;
    logic [COUNT_W-1:0] held_count;
    logic [1:0]         tap_phase;
    logic               last;
  } result_t;

  typedef struct packed {
    logic             scan;
    logic             add;
    logic             rem;
    logic [KEY_W-1:0] key;
  } list_cmd_t;

  typedef struct packed {
    logic done;
  } list_stat_t;

endpackage

### rtl/hkr_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkr_list
// held key list with a shared keycode comparator stepped one entry a cycle
// ----------------------------------------------------------------------------
module hkr_list (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hkr_pkg::list_cmd_t       cmd,
  output hkr_pkg::list_stat_t      stat,
  output hkr_pkg::slots_t          slots,
  output logic [hkr_pkg::CNT_W-1:0] total
);
  import hkr_pkg::*;

  logic [KEY_W-1:0] list_r   [LIST_DEPTH];
  logic [KEY_W-1:0] list_nxt [LIST_DEPTH];
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             found_r, found_nxt;
  logic             at_end;
  logic             hit;

  // the one comparator, walked over the list by idx_r
  assign at_end = (idx_r >= total_r);
  assign hit    = !at_end && (list_r[idx_r[IDX_W-1:0]] == cmd.key);

  assign stat.done  = cmd.scan && (hit || at_end);
  assign total      = total_r;

  always_comb begin
    idx_nxt   = idx_r;
    found_nxt = found_r;
    total_nxt = total_r;
    for (int j = 0; j < LIST_DEPTH; j++) begin
      list_nxt[j] = list_r[j];
    end

    if (!cmd.scan) begin
      idx_nxt = '0;
    end else begin
      found_nxt = hit;
      if (!(hit || at_end)) begin
        idx_nxt = idx_r + CNT_W'(1);
      end
    end

    // idx_r still points at the match during the edit cycle
    if (cmd.add && !found_r && (total_r < CNT_W'(LIST_DEPTH))) begin
      for (int j = 0; j < LIST_DEPTH; j++) begin
        if (CNT_W'(j) == total_r) begin
          list_nxt[j] = cmd.key;
        end
      end
      total_nxt = total_r + CNT_W'(1);
    end else if (cmd.rem && found_r) begin
      for (int j = 0; j < LIST_DEPTH; j++) begin
        if (CNT_W'(j) >= idx_r) begin
          if (j < LIST_DEPTH - 1) begin
            list_nxt[j] = list_r[j+1];
          end else begin
            list_nxt[j] = '0;
          end
        end
      end
      total_nxt = total_r - CNT_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < REPORT_KEYS; i++) begin
      slots[i] = (CNT_W'(i) < total_r) ? list_r[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      idx_r   <= '0;
      found_r <= 1'b0;
    end else begin
      total_r <= total_nxt;
      idx_r   <= idx_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < LIST_DEPTH; j++) begin
      list_r[j] <= list_nxt[j];
    end
  end

endmodule

### rtl/hkr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkr_seq
// sequencer: decodes an action, drives list scans and edits, runs the tap
// phase machine and stages report attempts so the final one carries last
// ----------------------------------------------------------------------------
module hkr_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hkr_pkg::in_item_t           in_item,
  input  logic [hkr_pkg::DELAY_W-1:0] tap_delay,
  output hkr_pkg::list_cmd_t          cmd,
  input  hkr_pkg::list_stat_t         stat,
  input  hkr_pkg::slots_t             slots,
  input  logic [hkr_pkg::CNT_W-1:0]   total,
  input  logic                        out_free,
  output logic                        push,
  output hkr_pkg::result_t            push_data
);
  import hkr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_EDIT   = 8'b0000_0100,
    S_SEND1  = 8'b0000_1000,
    S_STEP   = 8'b0001_0000,
    S_SEND2  = 8'b0010_0000,
    S_TAPSET = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  // where to go once a list edit is done
  typedef enum logic [1:0] {
    RET_FIN   = 2'd0,
    RET_TASK  = 2'd1,
    RET_SEND2 = 2'd2
  } ret_t;

  state_t            state_r, state_nxt;
  ret_t              ret_r, ret_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              ready_r, ready_nxt;
  logic              acc_r, acc_nxt;
  logic [KEY_W-1:0]  scan_key_r, scan_key_nxt;
  logic              add_r, add_nxt;
  logic              tap_pre_r, tap_pre_nxt;
  logic              pending_r, pending_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [KEY_W-1:0]  tap_key_r, tap_key_nxt;
  logic [TIME_W-1:0] deadline_r, deadline_nxt;
  logic              pend_v_r, pend_v_nxt;
  result_t           pend_r, pend_nxt;
  result_t           attempt;
  logic [TIME_W-1:0] diff;
  logic              due;
  logic              send_try;

  assign in_ready = (state_r == S_IDLE);
  assign diff     = now_r - deadline_r;
  assign due      = !diff[TIME_W-1];
  assign send_try = pending_r && ready_r;

  always_comb begin
    attempt.slots      = slots;
    attempt.was_sent   = acc_r;
    attempt.held_count = COUNT_W'(total);
    attempt.tap_phase  = mode_r;
    attempt.last       = 1'b0;
  end

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    key_nxt      = key_r;
    now_nxt      = now_r;
    ready_nxt    = ready_r;
    acc_nxt      = acc_r;
    scan_key_nxt = scan_key_r;
    add_nxt      = add_r;
    tap_pre_nxt  = tap_pre_r;
    pending_nxt  = pending_r;
    mode_nxt     = mode_r;
    tap_key_nxt  = tap_key_r;
    deadline_nxt = deadline_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    push         = 1'b0;
    push_data    = pend_r;
    cmd.scan     = 1'b0;
    cmd.add      = 1'b0;
    cmd.rem      = 1'b0;
    cmd.key      = scan_key_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt     = in_item.keycode;
          now_nxt     = in_item.now_ms;
          ready_nxt   = in_item.host_ready;
          acc_nxt     = in_item.host_accepts;
          tap_pre_nxt = 1'b0;
          case (in_item.action)
            ACT_PRESS: begin
              scan_key_nxt = in_item.keycode;
              add_nxt      = 1'b1;
              ret_nxt      = RET_FIN;
              state_nxt    = S_SCAN;
            end
            ACT_RELEASE: begin
              scan_key_nxt = in_item.keycode;
              add_nxt      = 1'b0;
              ret_nxt      = RET_FIN;
              state_nxt    = S_SCAN;
            end
            ACT_REPORT: begin
              pending_nxt = 1'b1;
              state_nxt   = S_SEND1;
            end
            ACT_TAP: begin
              if (mode_r != PHASE_IDLE) begin
                // force release of the tap still in flight
                scan_key_nxt = tap_key_r;
                add_nxt      = 1'b0;
                ret_nxt      = RET_TASK;
                tap_pre_nxt  = 1'b1;
                pending_nxt  = 1'b1;
                mode_nxt     = PHASE_IDLE;
                tap_key_nxt  = '0;
                state_nxt    = S_SCAN;
              end else begin
                state_nxt = S_TAPSET;
              end
            end
            ACT_POLL: begin
              state_nxt = S_SEND1;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.done) begin
          state_nxt = S_EDIT;
        end
      end

      S_EDIT: begin
        cmd.add = add_r;
        cmd.rem = !add_r;
        case (ret_r)
          RET_FIN:   state_nxt = S_FIN;
          RET_TASK:  state_nxt = S_SEND1;
          RET_SEND2: state_nxt = S_SEND2;
          default:   state_nxt = S_FIN;
        endcase
      end

      S_SEND1, S_SEND2: begin
        if (!(send_try && pend_v_r && !out_free)) begin
          if (send_try) begin
            // older staged attempt goes out, this one waits to learn if it is last
            push       = pend_v_r;
            pend_nxt   = attempt;
            pend_v_nxt = 1'b1;
            if (acc_r) begin
              pending_nxt = 1'b0;
            end
          end
          if (state_r == S_SEND1) begin
            state_nxt = S_STEP;
          end else if (tap_pre_r) begin
            tap_pre_nxt = 1'b0;
            state_nxt   = S_TAPSET;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_STEP: begin
        state_nxt = S_SEND2;
        case (mode_r)
          PHASE_PRESS: begin
            if (!pending_r && due) begin
              scan_key_nxt = tap_key_r;
              add_nxt      = 1'b0;
              ret_nxt      = RET_SEND2;
              pending_nxt  = 1'b1;
              mode_nxt     = PHASE_RELEASE;
              state_nxt    = S_SCAN;
            end
          end
          PHASE_RELEASE: begin
            if (!pending_r) begin
              mode_nxt    = PHASE_IDLE;
              tap_key_nxt = '0;
            end
          end
          default: begin
          end
        endcase
      end

      S_TAPSET: begin
        tap_key_nxt  = key_r;
        deadline_nxt = now_r + TIME_W'(tap_delay);
        mode_nxt     = PHASE_PRESS;
        pending_nxt  = 1'b1;
        scan_key_nxt = key_r;
        add_nxt      = 1'b1;
        ret_nxt      = RET_TASK;
        state_nxt    = S_SCAN;
      end

      S_FIN: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push           = 1'b1;
          push_data.last = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= RET_FIN;
      tap_pre_r  <= 1'b0;
      pending_r  <= 1'b0;
      mode_r     <= PHASE_IDLE;
      tap_key_r  <= '0;
      deadline_r <= '0;
      pend_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      tap_pre_r  <= tap_pre_nxt;
      pending_r  <= pending_nxt;
      mode_r     <= mode_nxt;
      tap_key_r  <= tap_key_nxt;
      deadline_r <= deadline_nxt;
      pend_v_r   <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    now_r      <= now_nxt;
    ready_r    <= ready_nxt;
    acc_r      <= acc_nxt;
    scan_key_r <= scan_key_nxt;
    add_r      <= add_nxt;
    pend_r     <= pend_nxt;
  end

endmodule

### rtl/hid_key_rollover_tap_top.sv
`timescale 1ns / 1ps
// A press or release scans and edits the held list before the block is ready again;
// a report or poll sends, steps the tap machine and, when the timed release runs,
// adds a list edit; a tap adds list edits of its own, more for a tap over a tap in
// flight; output stalls hold the block longer.
// The block is not ready while it works, so it takes a new item only once the last is done.
// Synchronous active-low reset empties the list, idles the tap machine, loads 5 ms.
// ----------------------------------------------------------------------------
// hid_key_rollover_tap_top
// six-key rollover report builder with a timed encoder tap release
// ----------------------------------------------------------------------------
`include "hid_key_rollover_tap_top_assert.svh"

module hid_key_rollover_tap_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // keycode[7:0], now_ms[39:8], host_ready[40], host_accepts[41], zero[47:42]
  input  logic [47:0] in_tdata,
  // action[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // slot0[7:0] .. slot5[47:40], was_sent[48], held_count[53:49], tap_phase[55:54]
  output logic [55:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [hkr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hkr_pkg::*;

  in_item_t           item;
  list_cmd_t          cmd;
  list_stat_t         stat;
  slots_t             slots;
  logic [CNT_W-1:0]   total;
  logic               push;
  result_t            push_data;
  logic               out_free;
  logic               out_v_r;
  result_t            out_r;
  logic [DELAY_W-1:0] delay_r;
  logic               cfg_sel_delay;

  assign item.action       = in_tuser;
  assign item.keycode      = in_tdata[7:0];
  assign item.now_ms       = in_tdata[39:8];
  assign item.host_ready   = in_tdata[40];
  assign item.host_accepts = in_tdata[41];

  // configuration register
  assign cfg_pready    = 1'b1;
  assign cfg_sel_delay = (cfg_paddr[2] == REG_TAP_DELAY);
  assign cfg_prdata    = cfg_sel_delay ? {{(32-DELAY_W){1'b0}}, delay_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_delay) begin
      delay_r <= cfg_pwdata[DELAY_W-1:0];
    end
  end

  hkr_list u_list (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat),
    .slots (slots),
    .total (total)
  );

  hkr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (item),
    .tap_delay (delay_r),
    .cmd       (cmd),
    .stat      (stat),
    .slots     (slots),
    .total     (total),
    .out_free  (out_free),
    .push      (push),
    .push_data (push_data)
  );

  // output register
  assign out_free = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r <= push_data;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.tap_phase, out_r.held_count, out_r.was_sent, out_r.slots};
  assign out_tlast  = out_r.last;

  `HKR_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready, "ready after transfer")
  `HKR_ASSERT_SAME(a_push_room, push && out_v_r, out_tready, "result pushed over a held one")
  `HKR_ASSERT_SAME(a_phase_legal, out_v_r, out_r.tap_phase != PHASE_SPARE, "unused tap phase")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the six-key rollover report block: random key,
// report, poll and encoder tap traffic against a built-in report predictor,
// run through several tap delays and idle/stall mixes on both streams
// ----------------------------------------------------------------------------
module tb_top;
  import hkr_pkg::*;

  localparam int          CLK_HALF      = 10;
  localparam int          RESET_CYCLES  = 7;
  localparam int          SETTLE_CYCLES = 100;
  localparam int          PHASE_EVENTS  = 62;
  localparam int          CYCLE_LIMIT   = 500000;
  localparam logic [2:0]  ACT_CODE_MAX  = 3'd7;
  localparam logic [CFG_ADDR_W-1:0] TAP_DELAY_ADDR = {REG_TAP_DELAY, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  hid_key_rollover_tap_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // report predictor state
  logic [KEY_W-1:0]  held_keys [LIST_DEPTH];
  int unsigned       held_n = 0;
  bit                report_dirty = 1'b0;
  logic [1:0]        tap_mode = PHASE_IDLE;
  logic [KEY_W-1:0]  tap_key = '0;
  logic [TIME_W-1:0] tap_due_ms = '0;
  logic [DELAY_W-1:0] tap_delay = DELAY_RESET;
  bit                cur_ready, cur_accepts;
  result_t           burst_q[$];
  result_t           exp_reports[$];

  in_item_t          key_events[$];
  in_item_t          drv_item, mon_item;
  logic [TIME_W-1:0] clock_ms = 32'hFFFF_FFF8;
  logic [KEY_W-1:0]  key_pool [6];
  int                event_count = 0;
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  int                mismatches = 0;
  int unsigned       cycle_count = 0;
  logic              in_acc = 1'b0;
  logic [31:0]       prdata_q = '0;

  function automatic void key_add(logic [KEY_W-1:0] k);
    for (int i = 0; i < held_n; i++)
      if (held_keys[i] == k) return;
    if (held_n < LIST_DEPTH) begin
      held_keys[held_n] = k;
      held_n++;
    end
  endfunction

  function automatic void key_drop(logic [KEY_W-1:0] k);
    for (int i = 0; i < held_n; i++) begin
      if (held_keys[i] == k) begin
        for (int j = i; j + 1 < held_n; j++) held_keys[j] = held_keys[j+1];
        held_n--;
        held_keys[held_n] = '0;
        return;
      end
    end
  endfunction

  function automatic void send_attempt();
    result_t r;
    if (!report_dirty || !cur_ready || burst_q.size() >= 4) return;
    for (int i = 0; i < REPORT_KEYS; i++)
      r.slots[i] = (i < held_n) ? held_keys[i] : '0;
    r.was_sent   = cur_accepts;
    r.held_count = COUNT_W'(held_n);
    r.tap_phase  = tap_mode;
    r.last       = 1'b0;
    burst_q.push_back(r);
    if (cur_accepts) report_dirty = 1'b0;
  endfunction

  function automatic void run_task(logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] elapsed;
    send_attempt();
    elapsed = now - tap_due_ms;
    if (tap_mode == PHASE_PRESS) begin
      // release due once the wrapped difference is non-negative
      if (!report_dirty && !elapsed[TIME_W-1]) begin
        key_drop(tap_key);
        report_dirty = 1'b1;
        tap_mode = PHASE_RELEASE;
      end
    end else if (tap_mode == PHASE_RELEASE) begin
      if (!report_dirty) begin
        tap_mode = PHASE_IDLE;
        tap_key = '0;
      end
    end
    send_attempt();
  endfunction

  function automatic void predict_reports(in_item_t ev);
    result_t r;
    burst_q.delete();
    cur_ready = ev.host_ready;
    cur_accepts = ev.host_accepts;
    case (ev.action)
      ACT_PRESS:   key_add(ev.keycode);
      ACT_RELEASE: key_drop(ev.keycode);
      ACT_REPORT: begin
        report_dirty = 1'b1;
        run_task(ev.now_ms);
      end
      ACT_TAP: begin
        // a tap still in flight is released first
        if (tap_mode != PHASE_IDLE) begin
          key_drop(tap_key);
          report_dirty = 1'b1;
          tap_mode = PHASE_IDLE;
          tap_key = '0;
          run_task(ev.now_ms);
        end
        tap_key = ev.keycode;
        tap_due_ms = ev.now_ms + TIME_W'(tap_delay);
        tap_mode = PHASE_PRESS;
        key_add(ev.keycode);
        report_dirty = 1'b1;
        run_task(ev.now_ms);
      end
      ACT_POLL:    run_task(ev.now_ms);
      default: ;
    endcase
    foreach (burst_q[i]) begin
      r = burst_q[i];
      r.last = (i == burst_q.size() - 1);
      exp_reports.push_back(r);
    end
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // driver: one transfer per item, random gaps
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_acc) begin
      if (key_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_item = key_events.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= drv_item.action;
        in_tdata  <= {6'b0, drv_item.host_accepts, drv_item.host_ready,
                      drv_item.now_ms, drv_item.keycode};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    in_acc <= in_tvalid && in_tready;
    prdata_q <= cfg_prdata;
    if (rst_n && in_tvalid && in_tready) begin
      mon_item.action       = in_tuser;
      mon_item.keycode      = in_tdata[7:0];
      mon_item.now_ms       = in_tdata[39:8];
      mon_item.host_ready   = in_tdata[40];
      mon_item.host_accepts = in_tdata[41];
      predict_reports(mon_item);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected report, expected none, actual %0h last %0b",
                 $time, out_tdata, out_tlast);
      end else begin
        for (int i = 0; i < REPORT_KEYS; i++)
          check_field($sformatf("slot%0d", i), 32'(exp_reports[0].slots[i]),
                      32'(out_tdata[8*i +: 8]));
        check_field("was_sent", 32'(exp_reports[0].was_sent), 32'(out_tdata[48]));
        check_field("held_count", 32'(exp_reports[0].held_count), 32'(out_tdata[53:49]));
        check_field("tap_phase", 32'(exp_reports[0].tap_phase), 32'(out_tdata[55:54]));
        check_field("last", 32'(exp_reports[0].last), 32'(out_tlast));
        void'(exp_reports.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hid_key_rollover_tap_top test failed");
      $finish;
    end
  end

  task automatic queue_event(input logic [2:0] act, input logic [KEY_W-1:0] key,
                             input bit ready, input bit accepts, input logic [31:0] step);
    in_item_t ev;
    clock_ms = clock_ms + step;
    ev.action       = act;
    ev.keycode      = key;
    ev.now_ms       = clock_ms;
    ev.host_ready   = ready;
    ev.host_accepts = accepts;
    key_events.push_back(ev);
    if (act <= ACT_POLL) event_count++;
  endtask

  task automatic queue_rand(input logic [2:0] act, input logic [KEY_W-1:0] key);
    int p;
    logic [31:0] step;
    p = $urandom_range(0, 99);
    if (p < 70) step = $urandom_range(0, 8);
    else if (p < 95) step = $urandom_range(0, 120);
    else step = $urandom;
    queue_event(act, key, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 70, step);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, 5)];
    return KEY_W'($urandom_range(0, 255));
  endfunction

  task automatic wait_quiet();
    while (key_events.size() != 0 || in_tvalid) @(posedge clk);
    while (exp_reports.size() != 0) @(posedge clk);
  endtask

  task automatic set_tap_delay(input logic [DELAY_W-1:0] val);
    logic [31:0] rd;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= TAP_DELAY_ADDR;
    cfg_pwdata  <= {24'h0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tap_delay = val;
    // read back
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    rd = prdata_q;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    check_field("tap_delay readback", 32'(val), 32'(rd[7:0]));
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct,
                           input logic [DELAY_W-1:0] delay);
    int phase_start;
    bit paused;
    int pick;
    int n;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] base;
    wait_quiet();
    // press and release make no report, so let the block finish
    repeat (SETTLE_CYCLES) @(negedge clk);
    set_tap_delay(delay);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    for (int i = 0; i < 6; i++) key_pool[i] = KEY_W'($urandom_range(0, 255));
    phase_start = event_count;
    paused = 1'b0;
    while (event_count - phase_start < PHASE_EVENTS) begin
      if (!paused && event_count - phase_start >= PHASE_EVENTS / 2) begin
        wait_quiet();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // encoder tap followed by task polls
        queue_rand(ACT_TAP, pick_key());
        n = $urandom_range(2, 6);
        repeat (n) queue_rand(ACT_POLL, 8'(pick_key()));
      end else if (pick < 55) begin
        k = pick_key();
        queue_rand(ACT_PRESS, k);
        queue_rand(ACT_REPORT, pick_key());
        if ($urandom_range(0, 1)) queue_rand(ACT_PRESS, pick_key());
        queue_rand(ACT_RELEASE, k);
        queue_rand(ACT_POLL, pick_key());
      end else if (pick < 63) begin
        // fill the list up to or past its depth, then thin it out
        base = KEY_W'($urandom_range(0, 255));
        n = $urandom_range(14, 18);
        for (int i = 0; i < n; i++) queue_rand(ACT_PRESS, base + KEY_W'(i));
        queue_rand(ACT_REPORT, base);
        for (int i = 0; i < n; i++)
          if ($urandom_range(0, 1)) queue_rand(ACT_RELEASE, base + KEY_W'(i));
        queue_rand(ACT_REPORT, base);
      end else begin
        queue_rand(3'($urandom_range(0, ACT_CODE_MAX)), KEY_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < LIST_DEPTH; i++) held_keys[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_tap_delay(8'd3);

    // directed: empty report, list edge keys, host refusal, tap timing
    queue_event(ACT_REPORT,  8'h00, 1, 1, 0);
    queue_event(ACT_PRESS,   8'h00, 1, 1, 1);
    queue_event(ACT_PRESS,   8'hFF, 0, 0, 1);
    queue_event(ACT_PRESS,   8'hFF, 1, 1, 1);
    queue_event(ACT_RELEASE, 8'h5A, 1, 1, 1);
    queue_event(ACT_REPORT,  8'h00, 1, 0, 1);
    queue_event(ACT_REPORT,  8'h00, 0, 1, 1);
    queue_event(ACT_POLL,    8'h00, 1, 1, 1);
    queue_event(ACT_TAP,     8'h2C, 1, 1, 1);
    queue_event(ACT_POLL,    8'h00, 1, 1, 1);
    queue_event(ACT_POLL,    8'h00, 1, 1, 2);
    queue_event(ACT_POLL,    8'h00, 1, 1, 1);
    queue_event(ACT_TAP,     8'hFF, 1, 0, 1);
    queue_event(ACT_TAP,     8'h33, 1, 0, 1);
    queue_event(ACT_POLL,    8'h00, 1, 1, 16);
    queue_event(ACT_POLL,    8'h00, 1, 1, 1);
    queue_event(ACT_POLL + 3'd1, 8'hA5, 1, 1, 1);
    queue_event(ACT_CODE_MAX - 3'd1, 8'h5A, 1, 1, 1);
    queue_event(ACT_CODE_MAX, 8'hA5, 1, 1, 1);
    queue_event(ACT_RELEASE, 8'hFF, 1, 1, 1);
    queue_event(ACT_RELEASE, 8'h00, 1, 1, 1);
    queue_event(ACT_TAP,     8'h81, 1, 1, 1);
    queue_event(ACT_POLL,    8'h00, 1, 1, 32'h8000_0000);
    queue_event(ACT_POLL,    8'h00, 1, 1, 32'h8000_0000);
    queue_event(ACT_POLL,    8'h00, 1, 1, 1);

    run_phase(0, 0, 8'd0);
    run_phase(81, 0, 8'd255);
    run_phase(0, 81, DELAY_W'($urandom_range(1, 254)));
    run_phase(19, 19, DELAY_W'($urandom_range(1, 254)));

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("hid_key_rollover_tap_top test passed");
    end else begin
      $display("hid_key_rollover_tap_top test failed");
    end
    $finish;
  end

endmodule
